/* rtl/vnom_pkg.sv */
// ----------------------------------------------------------------------------
// vnom_pkg
// Shared constants, codes and controller/datapath command types for the
// voxel neighbour opacity mask block.
// ----------------------------------------------------------------------------
package vnom_pkg;

   localparam int BLOCK_EDGE_DEF = 16;

   localparam int OP_W    = 2;
   localparam int COORD_W = 4;
   localparam int FACE_W  = 3;
   localparam int INDEX_W = 12;
   localparam int MASK_W  = 6;

   localparam logic [OP_W-1:0] OP_LOAD_OWN   = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_NEIGH = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY      = 2'd2;

   localparam logic [FACE_W-1:0] FACE_X_NEG = 3'd0;
   localparam logic [FACE_W-1:0] FACE_X_POS = 3'd1;
   localparam logic [FACE_W-1:0] FACE_Y_NEG = 3'd2;
   localparam logic [FACE_W-1:0] FACE_Y_POS = 3'd3;
   localparam logic [FACE_W-1:0] FACE_Z_NEG = 3'd4;
   localparam logic [FACE_W-1:0] FACE_Z_POS = 3'd5;

   localparam int NUM_FACES = 6;

   typedef struct packed {
      logic accept;
      logic load_q;
      logic rd_a;
      logic rd_b;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic query_ok;
   } status_type;

endpackage

/* rtl/vnom_req_if.sv */
// ----------------------------------------------------------------------------
// vnom_req_if
// Request channel: load and query words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vnom_req_if;
   logic                        valid;
   logic                        ready;
   logic [vnom_pkg::OP_W-1:0]    opcode;
   logic [vnom_pkg::COORD_W-1:0] pos_x;
   logic [vnom_pkg::COORD_W-1:0] pos_y;
   logic [vnom_pkg::COORD_W-1:0] pos_z;
   logic                        opaque_bit;
   logic [vnom_pkg::FACE_W-1:0]  face_sel;

   modport source (output valid, opcode, pos_x, pos_y, pos_z, opaque_bit, face_sel,
                   input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, pos_z, opaque_bit, face_sel,
                   output ready);
endinterface

/* rtl/vnom_rsp_if.sv */
// ----------------------------------------------------------------------------
// vnom_rsp_if
// Response channel: voxel index and neighbour mask with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vnom_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vnom_pkg::INDEX_W-1:0] lin_index;
   logic [vnom_pkg::MASK_W-1:0]  neighbour_mask;

   modport source (output valid, lin_index, neighbour_mask, input ready);
   modport sink   (input valid, lin_index, neighbour_mask, output ready);
endinterface

/* rtl/voxel_neighbour_opacity_mask.sv */
// ----------------------------------------------------------------------------
// voxel_neighbour_opacity_mask
// Six-neighbour opacity mask of a voxel, from the own block store and the
// touching faces of the six neighbouring blocks.
// ----------------------------------------------------------------------------
// load words: accepted back to back while no query is in progress, written at the accept edge
// query: coordinates registered at accept; two read rounds on the dual-read
// own-voxel banks follow (x and y neighbours, then z neighbours); the result
// is registered when the response slot is free; the next word is taken after it
// reset clears the sequencer and the response valid; the stores keep contents
module voxel_neighbour_opacity_mask #(
   parameter int BLOCK_EDGE = vnom_pkg::BLOCK_EDGE_DEF
) (
   input logic       clock,
   input logic       reset,
   vnom_req_if.sink   req_chan,
   vnom_rsp_if.source rsp_chan
);

   vnom_pkg::cmd_type    cmd;
   vnom_pkg::status_type status;

   vnom_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   vnom_dpath #(
      .BLOCK_EDGE (BLOCK_EDGE)
   ) u_dpath (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_chan.opcode),
      .req_pos_x          (req_chan.pos_x),
      .req_pos_y          (req_chan.pos_y),
      .req_pos_z          (req_chan.pos_z),
      .req_opaque_bit     (req_chan.opaque_bit),
      .req_face_sel       (req_chan.face_sel),
      .rsp_lin_index      (rsp_chan.lin_index),
      .rsp_neighbour_mask (rsp_chan.neighbour_mask)
   );

endmodule

/* rtl/vnom_ctrl.sv */
// ----------------------------------------------------------------------------
// vnom_ctrl
// Sequencer: accepts words, steps a query through two read rounds and hands
// the result to the response register.
// ----------------------------------------------------------------------------
module vnom_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  vnom_pkg::status_type status,
   output vnom_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = (state_ff == ST_IDLE);
      cmd.accept = req_valid && req_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.query_ok) begin
               cmd.load_q = 1'b1;
               state_in   = ST_RD_A;
            end
         end
         ST_RD_A: begin
            cmd.rd_a = 1'b1;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.rd_b = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_push_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_ready))
      else $error("result pushed over an untaken word");

   a_query_starts_reads: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.query_ok) |=> (state_ff == ST_RD_A))
      else $error("accepted query did not start read round");

   a_push_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> rsp_valid_ff)
      else $error("pushed result not presented");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.accept)
      else $error("word accepted during query reads");

endmodule

/* rtl/vnom_dpath.sv */
// ----------------------------------------------------------------------------
// vnom_dpath
// Opacity stores and mask assembly: own voxels in two x-parity banks with
// two read ports each, one single-read store per neighbour face.
// ----------------------------------------------------------------------------
module vnom_dpath #(
   parameter int BLOCK_EDGE = vnom_pkg::BLOCK_EDGE_DEF
) (
   input  logic                         clock,
   input  vnom_pkg::cmd_type            cmd,
   output vnom_pkg::status_type         status,
   input  logic [vnom_pkg::OP_W-1:0]    req_opcode,
   input  logic [vnom_pkg::COORD_W-1:0] req_pos_x,
   input  logic [vnom_pkg::COORD_W-1:0] req_pos_y,
   input  logic [vnom_pkg::COORD_W-1:0] req_pos_z,
   input  logic                         req_opaque_bit,
   input  logic [vnom_pkg::FACE_W-1:0]  req_face_sel,
   output logic [vnom_pkg::INDEX_W-1:0] rsp_lin_index,
   output logic [vnom_pkg::MASK_W-1:0]  rsp_neighbour_mask
);

   localparam int CW         = vnom_pkg::COORD_W;
   localparam int LAST       = BLOCK_EDGE - 1;
   localparam int HALF       = (BLOCK_EDGE + 1) / 2;
   localparam int BANK_DEPTH = BLOCK_EDGE * BLOCK_EDGE * HALF;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int FACE_DEPTH = BLOCK_EDGE * BLOCK_EDGE;
   localparam int FACE_AW    = $clog2(FACE_DEPTH);
   localparam int NF         = vnom_pkg::NUM_FACES;

   function automatic logic [BANK_AW-1:0] bank_addr(input int x, input int y, input int z);
      bank_addr = BANK_AW'((y * BLOCK_EDGE + z) * HALF + (x >> 1));
   endfunction

   function automatic logic [FACE_AW-1:0] face_addr(input int a, input int b);
      face_addr = FACE_AW'(a * BLOCK_EDGE + b);
   endfunction

   function automatic logic in_block(input logic [CW-1:0] c);
      in_block = (int'(c) <= LAST);
   endfunction

   // write decode
   logic               in_range, on_face, own_we, face_we;
   logic [FACE_AW-1:0] face_waddr;
   logic [BANK_AW-1:0] own_waddr;

   always_comb begin
      in_range = in_block(req_pos_x) && in_block(req_pos_y) && in_block(req_pos_z);
      on_face    = 1'b0;
      face_waddr = face_addr(int'(req_pos_y), int'(req_pos_z));
      unique case (req_face_sel)
         vnom_pkg::FACE_X_NEG: on_face = (int'(req_pos_x) == LAST);
         vnom_pkg::FACE_X_POS: on_face = (req_pos_x == '0);
         vnom_pkg::FACE_Y_NEG: on_face = (int'(req_pos_y) == LAST);
         vnom_pkg::FACE_Y_POS: on_face = (req_pos_y == '0);
         vnom_pkg::FACE_Z_NEG: on_face = (int'(req_pos_z) == LAST);
         vnom_pkg::FACE_Z_POS: on_face = (req_pos_z == '0);
         default:              on_face = 1'b0;
      endcase
      if (req_face_sel == vnom_pkg::FACE_Y_NEG || req_face_sel == vnom_pkg::FACE_Y_POS) begin
         face_waddr = face_addr(int'(req_pos_z), int'(req_pos_x));
      end else if (req_face_sel == vnom_pkg::FACE_Z_NEG ||
                   req_face_sel == vnom_pkg::FACE_Z_POS) begin
         face_waddr = face_addr(int'(req_pos_y), int'(req_pos_x));
      end
      own_waddr = bank_addr(int'(req_pos_x), int'(req_pos_y), int'(req_pos_z));
      own_we  = cmd.accept && in_range && (req_opcode == vnom_pkg::OP_LOAD_OWN);
      face_we = cmd.accept && in_range && on_face &&
                (req_opcode == vnom_pkg::OP_LOAD_NEIGH);
      status.query_ok = in_range && (req_opcode == vnom_pkg::OP_QUERY);
   end

   // query coordinates
   logic [CW-1:0] qx_ff, qy_ff, qz_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_q) begin
         qx_ff <= req_pos_x;
         qy_ff <= req_pos_y;
         qz_ff <= req_pos_z;
      end
   end

   // neighbour coordinates, clamped at the block edge
   logic [CW:0] xm, xp, ym, yp, zm, zp;
   logic        x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;

   always_comb begin
      x_lo = (qx_ff == '0);
      y_lo = (qy_ff == '0);
      z_lo = (qz_ff == '0);
      x_hi = (int'(qx_ff) == LAST);
      y_hi = (int'(qy_ff) == LAST);
      z_hi = (int'(qz_ff) == LAST);
      xm = x_lo ? (CW+1)'(qx_ff) : (CW+1)'(qx_ff) - (CW+1)'(1);
      ym = y_lo ? (CW+1)'(qy_ff) : (CW+1)'(qy_ff) - (CW+1)'(1);
      zm = z_lo ? (CW+1)'(qz_ff) : (CW+1)'(qz_ff) - (CW+1)'(1);
      xp = x_hi ? (CW+1)'(qx_ff) : (CW+1)'(qx_ff) + (CW+1)'(1);
      yp = y_hi ? (CW+1)'(qy_ff) : (CW+1)'(qy_ff) + (CW+1)'(1);
      zp = z_hi ? (CW+1)'(qz_ff) : (CW+1)'(qz_ff) + (CW+1)'(1);
   end

   // own store read addresses: x neighbours sit in the other bank
   logic [1:0][1:0][BANK_AW-1:0] own_ra;
   logic [1:0][1:0]              own_rd;
   logic                         own_re;

   always_comb begin
      own_re = cmd.rd_a || cmd.rd_b;
      for (int b = 0; b < 2; b++) begin
         if (1'(b) != qx_ff[0]) begin
            own_ra[b][0] = bank_addr(int'(xm), int'(qy_ff), int'(qz_ff));
            own_ra[b][1] = bank_addr(int'(xp), int'(qy_ff), int'(qz_ff));
         end else if (cmd.rd_a) begin
            own_ra[b][0] = bank_addr(int'(qx_ff), int'(ym), int'(qz_ff));
            own_ra[b][1] = bank_addr(int'(qx_ff), int'(yp), int'(qz_ff));
         end else begin
            own_ra[b][0] = bank_addr(int'(qx_ff), int'(qy_ff), int'(zm));
            own_ra[b][1] = bank_addr(int'(qx_ff), int'(qy_ff), int'(zp));
         end
      end
   end

   for (genvar b = 0; b < 2; b++) begin : g_bank
      logic mem [BANK_DEPTH];
      logic rd0_ff, rd1_ff;

      always_ff @(posedge clock) begin
         if (own_we && (req_pos_x[0] == 1'(b))) begin
            mem[own_waddr] <= req_opaque_bit;
         end
         if (own_re) begin
            rd0_ff <= mem[own_ra[b][0]];
            rd1_ff <= mem[own_ra[b][1]];
         end
      end

      assign own_rd[b] = {rd1_ff, rd0_ff};
   end

   // face store read addresses
   logic [NF-1:0][FACE_AW-1:0] face_ra;
   logic [NF-1:0]              face_rd;

   always_comb begin
      face_ra[0] = face_addr(int'(qy_ff), int'(qz_ff));
      face_ra[1] = face_addr(int'(qy_ff), int'(qz_ff));
      face_ra[2] = face_addr(int'(qz_ff), int'(qx_ff));
      face_ra[3] = face_addr(int'(qz_ff), int'(qx_ff));
      face_ra[4] = face_addr(int'(qy_ff), int'(qx_ff));
      face_ra[5] = face_addr(int'(qy_ff), int'(qx_ff));
   end

   for (genvar k = 0; k < NF; k++) begin : g_face
      logic mem [FACE_DEPTH];
      logic rd_ff;

      always_ff @(posedge clock) begin
         if (face_we && (req_face_sel == vnom_pkg::FACE_W'(k))) begin
            mem[face_waddr] <= req_opaque_bit;
         end
         if (cmd.rd_a) begin
            rd_ff <= mem[face_ra[k]];
         end
      end

      assign face_rd[k] = rd_ff;
   end

   // x and y neighbours from the first read round
   logic [3:0] hold_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_b) begin
         hold_ff <= {own_rd[qx_ff[0]][1], own_rd[qx_ff[0]][0],
                     own_rd[~qx_ff[0]][1], own_rd[~qx_ff[0]][0]};
      end
   end

   // result assembly
   logic [vnom_pkg::MASK_W-1:0]  mask_in, mask_ff;
   logic [vnom_pkg::INDEX_W-1:0] index_in, index_ff;

   always_comb begin
      mask_in[0] = x_lo ? face_rd[0] : hold_ff[0];
      mask_in[1] = x_hi ? face_rd[1] : hold_ff[1];
      mask_in[2] = y_lo ? face_rd[2] : hold_ff[2];
      mask_in[3] = y_hi ? face_rd[3] : hold_ff[3];
      mask_in[4] = z_lo ? face_rd[4] : own_rd[qx_ff[0]][0];
      mask_in[5] = z_hi ? face_rd[5] : own_rd[qx_ff[0]][1];
      index_in = vnom_pkg::INDEX_W'(int'(qy_ff) * BLOCK_EDGE * BLOCK_EDGE +
                                    int'(qz_ff) * BLOCK_EDGE + int'(qx_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mask_ff  <= mask_in;
         index_ff <= index_in;
      end
   end

   assign rsp_lin_index      = index_ff;
   assign rsp_neighbour_mask = mask_ff;

endmodule

/* sim/tb_voxel_neighbour_opacity_mask.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voxel_neighbour_opacity_mask
// Drives load and query words into the voxel neighbour opacity mask block and
// checks every returned index and six-bit mask against a behavioral copy of
// the own-voxel and neighbour-face stores. A query is only issued once all six
// of its neighbour entries hold a written value. Directed edge and corner
// cases come first, then random traffic with random gaps on both channels, a
// back-to-back burst, and a long response hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_voxel_neighbour_opacity_mask;

   localparam int EDGE         = vnom_pkg::BLOCK_EDGE_DEF;
   localparam int CW           = vnom_pkg::COORD_W;
   localparam int FW           = vnom_pkg::FACE_W;
   localparam int IW           = vnom_pkg::INDEX_W;
   localparam int NF           = vnom_pkg::NUM_FACES;
   localparam int LAST         = EDGE - 1;
   localparam int FACE_AREA    = EDGE * EDGE;
   localparam int CUBE_VOL     = EDGE * EDGE * EDGE;
   localparam int FACE_CODES   = 1 << FW;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int REPORT_MAX   = 10;

   localparam logic [vnom_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [vnom_pkg::OP_W-1:0] opcode;
      logic [CW-1:0]             pos_x;
      logic [CW-1:0]             pos_y;
      logic [CW-1:0]             pos_z;
      logic                      opaque_bit;
      logic [FW-1:0]             face_sel;
   } vox_word_type;

   typedef struct {
      logic [IW-1:0]                 lin_index;
      logic [vnom_pkg::MASK_W-1:0]   neighbour_mask;
   } mask_result_type;

   logic clock = 1'b0;
   logic reset;

   vnom_req_if req_bus ();
   vnom_rsp_if rsp_bus ();

   voxel_neighbour_opacity_mask #(
      .BLOCK_EDGE(EDGE)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   bit own_store  [CUBE_VOL];
   bit own_known  [CUBE_VOL];
   bit face_store [NF * FACE_AREA];
   bit face_known [NF * FACE_AREA];

   mask_result_type expected_masks[$];

   int words_applied     = 0;
   int mismatches        = 0;
   int cycle_count       = 0;
   int rsp_hold_request  = 0;
   bit idle_on           = 1'b0;

   always #2 clock = ~clock;

   function automatic int own_slot(int x, int y, int z);
      return y * FACE_AREA + z * EDGE + x;
   endfunction

   // position within a face uses the two coordinates off the face axis
   function automatic int face_slot(int k, int x, int y, int z);
      int a;
      int b;
      if (k < int'(vnom_pkg::FACE_Y_NEG)) begin
         a = y;
         b = z;
      end else if (k < int'(vnom_pkg::FACE_Z_NEG)) begin
         a = z;
         b = x;
      end else begin
         a = y;
         b = x;
      end
      return k * FACE_AREA + a * EDGE + b;
   endfunction

   function automatic bit on_touching_face(vox_word_type w);
      case (w.face_sel)
         vnom_pkg::FACE_X_NEG: return w.pos_x == LAST;
         vnom_pkg::FACE_X_POS: return w.pos_x == 0;
         vnom_pkg::FACE_Y_NEG: return w.pos_y == LAST;
         vnom_pkg::FACE_Y_POS: return w.pos_y == 0;
         vnom_pkg::FACE_Z_NEG: return w.pos_z == LAST;
         vnom_pkg::FACE_Z_POS: return w.pos_z == 0;
         default:              return 1'b0;
      endcase
   endfunction

   // neighbour one step along k; past the edge it wraps onto the neighbour face
   function automatic bit step_to_neighbour(input int k, input int x, input int y,
                                            input int z, output int nx, output int ny,
                                            output int nz);
      bit crosses;
      nx = x;
      ny = y;
      nz = z;
      case (k)
         vnom_pkg::FACE_X_NEG: nx = x - 1;
         vnom_pkg::FACE_X_POS: nx = x + 1;
         vnom_pkg::FACE_Y_NEG: ny = y - 1;
         vnom_pkg::FACE_Y_POS: ny = y + 1;
         vnom_pkg::FACE_Z_NEG: nz = z - 1;
         default:              nz = z + 1;
      endcase
      crosses = nx < 0 || nx > LAST || ny < 0 || ny > LAST || nz < 0 || nz > LAST;
      nx = (nx + EDGE) % EDGE;
      ny = (ny + EDGE) % EDGE;
      nz = (nz + EDGE) % EDGE;
      return crosses;
   endfunction

   function automatic void track_word(vox_word_type w);
      mask_result_type r;
      int x;
      int y;
      int z;
      int nx;
      int ny;
      int nz;
      bit crosses;
      x = int'(w.pos_x);
      y = int'(w.pos_y);
      z = int'(w.pos_z);
      case (w.opcode)
         vnom_pkg::OP_LOAD_OWN: begin
            own_store[own_slot(x, y, z)] = w.opaque_bit;
            own_known[own_slot(x, y, z)] = 1'b1;
         end
         vnom_pkg::OP_LOAD_NEIGH: begin
            if (on_touching_face(w)) begin
               face_store[face_slot(int'(w.face_sel), x, y, z)] = w.opaque_bit;
               face_known[face_slot(int'(w.face_sel), x, y, z)] = 1'b1;
            end
         end
         vnom_pkg::OP_QUERY: begin
            r.lin_index      = IW'(own_slot(x, y, z));
            r.neighbour_mask = '0;
            for (int k = 0; k < NF; k++) begin
               crosses = step_to_neighbour(k, x, y, z, nx, ny, nz);
               r.neighbour_mask[k] = crosses ? face_store[face_slot(k, nx, ny, nz)]
                                             : own_store[own_slot(nx, ny, nz)];
            end
            expected_masks.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int rand_coord();
      if ($urandom_range(0, 9) < 3)
         return $urandom_range(0, 1) ? LAST : 0;
      return $urandom_range(0, LAST);
   endfunction

   function automatic bit rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic vox_word_type make_word(logic [vnom_pkg::OP_W-1:0] op, int x, int y,
                                              int z, bit opaque, int face);
      vox_word_type w;
      w.opcode     = op;
      w.pos_x      = CW'(x);
      w.pos_y      = CW'(y);
      w.pos_z      = CW'(z);
      w.opaque_bit = opaque;
      w.face_sel   = FW'(face);
      return w;
   endfunction

   task automatic send_word(vox_word_type w);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= w.opcode;
      req_bus.pos_x      <= w.pos_x;
      req_bus.pos_y      <= w.pos_y;
      req_bus.pos_z      <= w.pos_z;
      req_bus.opaque_bit <= w.opaque_bit;
      req_bus.face_sel   <= w.face_sel;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      track_word(w);
      words_applied++;
   endtask

   // writes any unwritten neighbour entry first, then asks for the mask
   task automatic query_voxel(int x, int y, int z);
      int nx;
      int ny;
      int nz;
      bit crosses;
      for (int k = 0; k < NF; k++) begin
         crosses = step_to_neighbour(k, x, y, z, nx, ny, nz);
         if (crosses && !face_known[face_slot(k, nx, ny, nz)])
            send_word(make_word(vnom_pkg::OP_LOAD_NEIGH, nx, ny, nz, rand_bit(), k));
         else if (!crosses && !own_known[own_slot(nx, ny, nz)])
            send_word(make_word(vnom_pkg::OP_LOAD_OWN, nx, ny, nz, rand_bit(),
                                $urandom_range(0, FACE_CODES - 1)));
      end
      send_word(make_word(vnom_pkg::OP_QUERY, x, y, z, rand_bit(),
                          $urandom_range(0, FACE_CODES - 1)));
   endtask

   task automatic send_face_load(int k, int x, int y, int z);
      vox_word_type w;
      w = make_word(vnom_pkg::OP_LOAD_NEIGH, x, y, z, rand_bit(), k);
      case (k)
         vnom_pkg::FACE_X_NEG: w.pos_x = CW'(LAST);
         vnom_pkg::FACE_X_POS: w.pos_x = '0;
         vnom_pkg::FACE_Y_NEG: w.pos_y = CW'(LAST);
         vnom_pkg::FACE_Y_POS: w.pos_y = '0;
         vnom_pkg::FACE_Z_NEG: w.pos_z = CW'(LAST);
         default:              w.pos_z = '0;
      endcase
      send_word(w);
   endtask

   // words the block must drop: unused opcode, bad face, voxel off its face
   task automatic send_noise();
      vox_word_type w;
      w = make_word(vnom_pkg::OP_LOAD_NEIGH, rand_coord(), rand_coord(), rand_coord(),
                    rand_bit(), $urandom_range(0, NF - 1));
      case ($urandom_range(0, 2))
         0: w.opcode = OP_UNUSED;
         1: w.face_sel = FW'($urandom_range(NF, FACE_CODES - 1));
         default: begin
            case (w.face_sel)
               vnom_pkg::FACE_X_NEG, vnom_pkg::FACE_X_POS:
                  w.pos_x = CW'($urandom_range(1, LAST - 1));
               vnom_pkg::FACE_Y_NEG, vnom_pkg::FACE_Y_POS:
                  w.pos_y = CW'($urandom_range(1, LAST - 1));
               default:
                  w.pos_z = CW'($urandom_range(1, LAST - 1));
            endcase
         end
      endcase
      send_word(w);
   endtask

   task automatic run_random_traffic(int n_words);
      int stop_at;
      int pick;
      stop_at = words_applied + n_words;
      while (words_applied < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            query_voxel(rand_coord(), rand_coord(), rand_coord());
         else if (pick < 70)
            send_word(make_word(vnom_pkg::OP_LOAD_OWN, rand_coord(), rand_coord(),
                                rand_coord(), rand_bit(),
                                $urandom_range(0, FACE_CODES - 1)));
         else if (pick < 85)
            send_face_load($urandom_range(0, NF - 1), rand_coord(), rand_coord(),
                           rand_coord());
         else
            send_noise();
      end
   endtask

   task automatic test_edge_voxels();
      idle_on = 1'b0;
      query_voxel(0, 0, 0);
      query_voxel(LAST, LAST, LAST);
      send_word(make_word(OP_UNUSED, 1, 0, 0, !own_store[own_slot(1, 0, 0)],
                          int'(vnom_pkg::FACE_X_NEG)));
      send_word(make_word(vnom_pkg::OP_LOAD_NEIGH, LAST, 0, 0,
                          !face_store[face_slot(int'(vnom_pkg::FACE_X_NEG), LAST, 0, 0)],
                          NF));
      send_word(make_word(vnom_pkg::OP_LOAD_NEIGH, 0, 0, LAST,
                          !face_store[face_slot(int'(vnom_pkg::FACE_Z_NEG), 0, 0, LAST)],
                          FACE_CODES - 1));
      send_word(make_word(vnom_pkg::OP_LOAD_NEIGH, 0, 0, 0,
                          !face_store[face_slot(int'(vnom_pkg::FACE_X_NEG), LAST, 0, 0)],
                          int'(vnom_pkg::FACE_X_NEG)));
      query_voxel(0, 0, 0);
      send_word(make_word(vnom_pkg::OP_LOAD_OWN, 1, 0, 0, !own_store[own_slot(1, 0, 0)],
                          int'(vnom_pkg::FACE_Z_POS)));
      send_word(make_word(vnom_pkg::OP_LOAD_NEIGH, LAST, 0, 0,
                          !face_store[face_slot(int'(vnom_pkg::FACE_X_NEG), LAST, 0, 0)],
                          int'(vnom_pkg::FACE_X_NEG)));
      query_voxel(0, 0, 0);
   endtask

   task automatic test_random_traffic(int n_words);
      idle_on = 1'b1;
      run_random_traffic(n_words);
   endtask

   task automatic test_back_to_back(int n_words);
      idle_on = 1'b0;
      run_random_traffic(n_words);
   endtask

   task automatic test_response_hold();
      idle_on = 1'b0;
      rsp_hold_request = HOLD_CYCLES;
      repeat (40) query_voxel(rand_coord(), rand_coord(), rand_coord());
   endtask

   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            stall_left = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : mask_checker
      mask_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_masks.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected word: index %0d mask %b", rsp_bus.lin_index,
                        rsp_bus.neighbour_mask);
         end else begin
            want = expected_masks.pop_front();
            if (want.lin_index !== rsp_bus.lin_index ||
                want.neighbour_mask !== rsp_bus.neighbour_mask) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("mismatch: index exp %0d got %0d, mask exp %b got %b",
                           want.lin_index, rsp_bus.lin_index,
                           want.neighbour_mask, rsp_bus.neighbour_mask);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.opcode     = vnom_pkg::OP_LOAD_OWN;
      req_bus.pos_x      = '0;
      req_bus.pos_y      = '0;
      req_bus.pos_z      = '0;
      req_bus.opaque_bit = 1'b0;
      req_bus.face_sel   = vnom_pkg::FACE_X_NEG;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_voxels();
      test_random_traffic(1000);
      test_back_to_back(300);
      test_response_hold();
      test_random_traffic(1650 - words_applied);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_masks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
